FILE: rtl/inas_pkg.sv
package inas_pkg;

  // Array geometry
  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int LINK_BITS  = 16;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the request and result transfers
  localparam int MODE_W  = 3;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int LNK_W   = 16;
  localparam int FILL_W  = 7;
  localparam int STAT_W  = 2;

  // Width wide enough to compare a position against the fill count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  // Request mode codes
  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SWAP   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_TOP    = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd7;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_READ,
    OP_WRITE,
    OP_SWAP,
    OP_REMOVE,
    OP_POP,
    OP_TOP,
    OP_SEARCH
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RD_OUT,
    B_SWAP_B,
    B_SWAP_WA,
    B_SWAP_WB,
    B_REMOVE,
    B_SEARCH
  } bst_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position_a;
    logic [POS_W-1:0]  position_b;
    logic [VAL_W-1:0]  entry_value;
    logic [LNK_W-1:0]  entry_left;
    logic [LNK_W-1:0]  entry_right;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  out_value;
    logic [LNK_W-1:0]  out_left;
    logic [LNK_W-1:0]  out_right;
    logic              found;
    logic [FILL_W-1:0] fill_count;
    logic [STAT_W-1:0] status;
  } res_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [LINK_BITS-1:0]  left;
    logic [LINK_BITS-1:0]  right;
  } slot_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    slot_t            item;
  } cmd_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

endpackage

FILE: rtl/inas_front.sv
module inas_front import inas_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  req_t   in_req,
  output logic   in_stall,
  output qhead_t q_head,
  input  logic   q_pop
);

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec_cmd;
  logic       push_c;

  // mode decode
  always_comb begin
    dec_cmd.pos_a       = in_req.position_a;
    dec_cmd.pos_b       = in_req.position_b;
    dec_cmd.item.value  = in_req.entry_value[VALUE_BITS-1:0];
    dec_cmd.item.left   = in_req.entry_left[LINK_BITS-1:0];
    dec_cmd.item.right  = in_req.entry_right[LINK_BITS-1:0];
    unique case (in_req.mode)
      MODE_PUSH:   dec_cmd.op = OP_PUSH;
      MODE_READ:   dec_cmd.op = OP_READ;
      MODE_WRITE:  dec_cmd.op = OP_WRITE;
      MODE_SWAP:   dec_cmd.op = OP_SWAP;
      MODE_REMOVE: dec_cmd.op = OP_REMOVE;
      MODE_POP:    dec_cmd.op = OP_POP;
      MODE_TOP:    dec_cmd.op = OP_TOP;
      default:     dec_cmd.op = OP_SEARCH;
    endcase
  end

  assign in_stall     = (cnt_r == 2'd2);
  assign push_c       = in_valid && !in_stall;
  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_c) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (q_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push_c && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push_c && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_c) begin
      q_mem_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

FILE: rtl/inas_back.sv
module inas_back import inas_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  qhead_t q_head,
  output logic   q_pop,
  output logic   out_valid,
  output res_t   out_result,
  input  logic   out_stall
);

  slot_t             mem [DEPTH];
  slot_t             rdata_r;
  bst_t              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  cmd_t              cur_r, cur_nxt;
  slot_t             tmp_r, tmp_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;

  logic              we_c, re_c;
  logic [ADDR_W-1:0] waddr_c, raddr_c;
  slot_t             wdata_c;
  logic              res_load_c;
  res_t              res_c;

  logic              out_free;
  logic [CMP_W-1:0]  pa_ext, pb_ext, cnt_ext, idx_ext;
  logic              pa_ok, pb_ok;
  cmd_t              hc;

  assign out_free = !out_valid_r || !out_stall;
  assign hc       = q_head.cmd;
  assign cnt_ext  = CMP_W'(count_r);
  assign pa_ext   = CMP_W'(hc.pos_a);
  assign pb_ext   = CMP_W'(hc.pos_b);
  assign idx_ext  = CMP_W'(idx_r);
  assign pa_ok    = pa_ext < cnt_ext;
  assign pb_ok    = pb_ext < cnt_ext;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    cur_nxt    = cur_r;
    tmp_nxt    = tmp_r;
    q_pop      = 1'b0;
    we_c       = 1'b0;
    re_c       = 1'b0;
    waddr_c    = '0;
    raddr_c    = '0;
    wdata_c    = hc.item;
    res_load_c = 1'b0;
    res_c      = '0;
    res_c.fill_count = FILL_W'(count_r);
    res_c.status     = ST_OK;

    unique case (state_r)
      B_IDLE: begin
        if (q_head.valid && out_free) begin
          q_pop   = 1'b1;
          cur_nxt = hc;
          if (hc.op == OP_PUSH) begin
            res_load_c = 1'b1;
            if (count_r == CNT_W'(DEPTH)) begin
              res_c.status = ST_FULL;
            end else begin
              we_c      = 1'b1;
              waddr_c   = ADDR_W'(count_r);
              count_nxt = count_r + 1'b1;
              res_c.fill_count = FILL_W'(count_nxt);
            end
          end else if (count_r == '0) begin
            res_load_c   = 1'b1;
            res_c.status = ST_EMPTY;
          end else begin
            unique case (hc.op)
              OP_READ: begin
                if (pa_ok) begin
                  re_c      = 1'b1;
                  raddr_c   = ADDR_W'(hc.pos_a);
                  state_nxt = B_RD_OUT;
                end else begin
                  res_load_c   = 1'b1;
                  res_c.status = ST_RANGE;
                end
              end
              OP_WRITE: begin
                res_load_c = 1'b1;
                if (pa_ok) begin
                  we_c    = 1'b1;
                  waddr_c = ADDR_W'(hc.pos_a);
                end else begin
                  res_c.status = ST_RANGE;
                end
              end
              OP_SWAP: begin
                if (pa_ok && pb_ok) begin
                  re_c      = 1'b1;
                  raddr_c   = ADDR_W'(hc.pos_a);
                  state_nxt = B_SWAP_B;
                end else begin
                  res_load_c   = 1'b1;
                  res_c.status = ST_RANGE;
                end
              end
              OP_REMOVE: begin
                if (!pa_ok) begin
                  res_load_c   = 1'b1;
                  res_c.status = ST_RANGE;
                end else if (pa_ext + 1'b1 < cnt_ext) begin
                  re_c      = 1'b1;
                  raddr_c   = ADDR_W'(pa_ext + 1'b1);
                  idx_nxt   = CNT_W'(hc.pos_a);
                  state_nxt = B_REMOVE;
                end else begin
                  // removing the top entry: no shift needed
                  count_nxt        = count_r - 1'b1;
                  res_load_c       = 1'b1;
                  res_c.fill_count = FILL_W'(count_nxt);
                end
              end
              OP_POP: begin
                count_nxt = count_r - 1'b1;
                re_c      = 1'b1;
                raddr_c   = ADDR_W'(count_nxt);
                state_nxt = B_RD_OUT;
              end
              OP_TOP: begin
                re_c      = 1'b1;
                raddr_c   = ADDR_W'(count_r - 1'b1);
                state_nxt = B_RD_OUT;
              end
              OP_SEARCH: begin
                re_c      = 1'b1;
                raddr_c   = '0;
                idx_nxt   = CNT_W'(1);
                state_nxt = B_SEARCH;
              end
              OP_PUSH: begin
                state_nxt = B_IDLE;
              end
            endcase
          end
        end
      end

      B_RD_OUT: begin
        res_load_c      = 1'b1;
        res_c.out_value = VAL_W'(rdata_r.value);
        res_c.out_left  = LNK_W'(rdata_r.left);
        res_c.out_right = LNK_W'(rdata_r.right);
        state_nxt       = B_IDLE;
      end

      B_SWAP_B: begin
        tmp_nxt   = rdata_r;
        re_c      = 1'b1;
        raddr_c   = ADDR_W'(cur_r.pos_b);
        state_nxt = B_SWAP_WA;
      end

      B_SWAP_WA: begin
        we_c      = 1'b1;
        waddr_c   = ADDR_W'(cur_r.pos_a);
        wdata_c   = rdata_r;
        state_nxt = B_SWAP_WB;
      end

      B_SWAP_WB: begin
        we_c       = 1'b1;
        waddr_c    = ADDR_W'(cur_r.pos_b);
        wdata_c    = tmp_r;
        res_load_c = 1'b1;
        state_nxt  = B_IDLE;
      end

      B_REMOVE: begin
        // write back the entry read last cycle, fetch the next one
        we_c    = 1'b1;
        waddr_c = ADDR_W'(idx_r);
        wdata_c = rdata_r;
        if (idx_ext + 2'd2 < cnt_ext) begin
          re_c    = 1'b1;
          raddr_c = ADDR_W'(idx_ext + 2'd2);
          idx_nxt = idx_r + 1'b1;
        end else begin
          count_nxt        = count_r - 1'b1;
          res_load_c       = 1'b1;
          res_c.fill_count = FILL_W'(count_nxt);
          state_nxt        = B_IDLE;
        end
      end

      B_SEARCH: begin
        if (rdata_r.value == cur_r.item.value) begin
          res_load_c  = 1'b1;
          res_c.found = 1'b1;
          state_nxt   = B_IDLE;
        end else if (idx_r >= count_r) begin
          res_load_c = 1'b1;
          state_nxt  = B_IDLE;
        end else begin
          re_c    = 1'b1;
          raddr_c = ADDR_W'(idx_r);
          idx_nxt = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load_c) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cur_r <= cur_nxt;
    tmp_r <= tmp_nxt;
    if (res_load_c) begin
      out_res_r <= res_c;
    end
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[waddr_c] <= wdata_c;
    end
    if (re_c) begin
      rdata_r <= mem[raddr_c];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

endmodule

FILE: rtl/indexed_node_array_stack.sv
// Array-backed stack of up to 64 entries (32-bit value plus two 16-bit link
// words) with indexed access. Every request transfer yields exactly one
// result transfer, in order. Requests land in a two-entry queue, so until
// the queue is full the input keeps taking transfers while the execution
// side works and while a result waits on out_stall. The entry store is a
// single-port-write, registered-read memory, and that one port pair sets
// the cost of each mode: push, write and every failed request finish from
// idle; read, top and pop pass through a read-out state; swap reads both
// entries and then writes both back; remove at position p moves each later
// entry down one place, one per cycle; search walks the held entries one
// per cycle, stopping at the first match. No clearing pass is run after
// reset: only the fill count is cleared, and entries are read only below it.
// Status: 0 ok, 1 full on push, 2 empty, 3 position out of range; on a
// failed request the entry fields and found are zero.
module indexed_node_array_stack import inas_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  req_t in_req,
  output logic in_stall,
  output logic out_valid,
  output res_t out_result,
  input  logic out_stall
);

  qhead_t q_head;
  logic   q_pop;

  // front: accept and decode requests into the command queue
  inas_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_req   (in_req),
    .in_stall (in_stall),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // back: checks against the fill count, runs the memory sequence,
  // holds the result register
  inas_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_result (out_result),
    .out_stall  (out_stall)
  );

  // fill count never exceeds the array depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.fill_count <= FILL_W'(DEPTH)))
    else $error("fill count above depth");

  // full is only reported with the array at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status == ST_FULL) |->
      (out_result.fill_count == FILL_W'(DEPTH)))
    else $error("full status with room left");

  // empty is only reported with nothing held
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status == ST_EMPTY) |->
      (out_result.fill_count == '0))
    else $error("empty status with entries held");

  // a hit is only reported on a successful request
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.found) |-> (out_result.status == ST_OK))
    else $error("found set on failed request");

endmodule

FILE: test/tb_top.sv
module tb_top;
  import inas_pkg::*;

  // Run shape
  localparam int RANDOM_ITEMS   = 1500;
  localparam int QUIET_ITEMS    = 150;   // tail of the run with no idling at all
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES   = 200;   // > longest op (search or remove)
  localparam int MAX_REPORTS    = 100;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_kind_t;

  // One row of the directed sequence; when fixed_res is set the expected
  // result is written out in the row, otherwise the array model supplies it.
  typedef struct {
    req_t req;
    bit   fixed_res;
    res_t want;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_req    = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  res_t out_result;

  // Array model state
  slot_t stack_mem [DEPTH];
  int    held;

  // Results the block still owes us, oldest first
  res_t  owed_results [$];

  logic [MODE_W-1:0] mode_codes [8] = '{MODE_PUSH, MODE_READ, MODE_WRITE, MODE_SWAP,
                                        MODE_REMOVE, MODE_POP, MODE_TOP, MODE_SEARCH};

  // Idle control, changed per segment by the stimulus process
  int idle_pct = 0;
  bit quiet    = 1'b0;

  // Bookkeeping
  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int max_held      = 0;
  int full_pushes   = 0;
  int range_fails   = 0;
  int empty_fails   = 0;
  int search_hits   = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;

  dir_row_t directed_rows [$];

  always #5 clk = ~clk;

  indexed_node_array_stack i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req     (in_req),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_result (out_result),
    .out_stall  (out_stall)
  );

  // ---------------------------------------------------------------------------
  // Array model: applies one accepted request and returns what the block
  // must answer. Positions are only ever read below the fill count, so the
  // never-written part of the store is never touched.
  // ---------------------------------------------------------------------------
  task automatic apply_request(input req_t r, output res_t res);
    slot_t item;
    slot_t tmp;
    int    pa;
    int    pb;
    item.value = r.entry_value;
    item.left  = r.entry_left;
    item.right = r.entry_right;
    pa         = int'(r.position_a);
    pb         = int'(r.position_b);
    res        = '0;
    res.status = ST_OK;
    if (r.mode == MODE_PUSH) begin
      if (held >= DEPTH) begin
        res.status = ST_FULL;
        full_pushes++;
      end else begin
        stack_mem[held] = item;
        held++;
      end
    end else if (held == 0) begin
      // every non-push mode on an empty array
      res.status = ST_EMPTY;
      empty_fails++;
    end else begin
      case (r.mode)
        MODE_READ: begin
          if (pa >= held) res.status = ST_RANGE;
          else begin
            res.out_value = stack_mem[pa].value;
            res.out_left  = stack_mem[pa].left;
            res.out_right = stack_mem[pa].right;
          end
        end
        MODE_WRITE: begin
          if (pa >= held) res.status = ST_RANGE;
          else stack_mem[pa] = item;
        end
        MODE_SWAP: begin
          if (pa >= held || pb >= held) res.status = ST_RANGE;
          else begin
            tmp           = stack_mem[pa];
            stack_mem[pa] = stack_mem[pb];
            stack_mem[pb] = tmp;
          end
        end
        MODE_REMOVE: begin
          if (pa >= held) res.status = ST_RANGE;
          else begin
            for (int i = pa; i + 1 < held; i++) stack_mem[i] = stack_mem[i + 1];
            held--;
          end
        end
        MODE_POP: begin
          held--;
          res.out_value = stack_mem[held].value;
          res.out_left  = stack_mem[held].left;
          res.out_right = stack_mem[held].right;
        end
        MODE_TOP: begin
          res.out_value = stack_mem[held - 1].value;
          res.out_left  = stack_mem[held - 1].left;
          res.out_right = stack_mem[held - 1].right;
        end
        default: begin
          // search: value only, links ignored, first hit wins
          for (int i = 0; i < held; i++) begin
            if (stack_mem[i].value == item.value) begin
              res.found = 1'b1;
              break;
            end
          end
          if (res.found) search_hits++;
        end
      endcase
      if (res.status == ST_RANGE) range_fails++;
    end
    res.fill_count = FILL_W'(held);
    if (held > max_held) max_held = held;
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Request side. Valid goes up with the payload and stays up until the
  // transfer; in_req is not touched while stalled. After a transfer the
  // line is only lowered when a gap follows, so back-to-back requests keep
  // valid high without a drop.
  // ---------------------------------------------------------------------------
  task automatic send_request(input req_t r, input bit fixed_res, input res_t want);
    res_t predicted;
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    apply_request(r, predicted);
    owed_results.push_back(fixed_res ? want : predicted);
    items_sent++;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic dir_row_t row(input logic [MODE_W-1:0] mode, input int pa, input int pb,
                                   input logic [VAL_W-1:0] value,
                                   input logic [LNK_W-1:0] lft, input logic [LNK_W-1:0] rgt,
                                   input bit fixed_res, input logic [STAT_W-1:0] st,
                                   input int fill);
    dir_row_t d;
    d.req.mode        = mode;
    d.req.position_a  = POS_W'(pa);
    d.req.position_b  = POS_W'(pb);
    d.req.entry_value = value;
    d.req.entry_left  = lft;
    d.req.entry_right = rgt;
    d.fixed_res       = fixed_res;
    // fixed rows are failures or pushes: entry fields and found stay zero
    d.want            = '0;
    d.want.status     = st;
    d.want.fill_count = FILL_W'(fill);
    return d;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input seg_kind_t kind);
    int w [8];
    int roll;
    int acc;
    case (kind)
      //                push rd  wr  swp rem pop top srch
      SEG_FILL:  w = '{ 70,  6,  6,  5,  2,  2,  4,  5};
      SEG_DRAIN: w = '{  8,  8,  8,  8, 28, 25,  7,  8};
      default:   w = '{ 30, 10, 10, 10, 10, 10,  8, 12};
    endcase
    roll = $urandom_range(0, 99);
    acc  = 0;
    for (int m = 0; m < 8; m++) begin
      acc += w[m];
      if (roll < acc) return mode_codes[m];
    end
    return MODE_SEARCH;
  endfunction

  // Mostly in-range positions and values already held (so searches hit and
  // duplicates show up), with a slice of raw noise over the full field space.
  function automatic req_t random_request(input seg_kind_t kind);
    req_t r;
    int   roll;
    r.mode        = pick_mode(kind);
    r.position_a  = POS_W'($urandom_range(0, 63));
    r.position_b  = POS_W'($urandom_range(0, 63));
    r.entry_value = $urandom;
    r.entry_left  = LNK_W'($urandom);
    r.entry_right = LNK_W'($urandom);
    if ($urandom_range(0, 99) < 8) return r;
    if (held > 0) begin
      if ($urandom_range(0, 9) != 0) r.position_a = POS_W'($urandom_range(0, held - 1));
      if ($urandom_range(0, 9) != 0) r.position_b = POS_W'($urandom_range(0, held - 1));
      if ($urandom_range(0, 99) < 40)
        r.entry_value = stack_mem[$urandom_range(0, held - 1)].value;
    end
    roll = $urandom_range(0, 19);
    if (roll == 0) r.entry_value = '0;
    else if (roll == 1) r.entry_value = '1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall in random bursts, none in quiet tail.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (quiet) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Compare each result transfer against the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        flag_error($sformatf("result with nothing owed: %p", out_result));
      end else begin
        res_t want;
        want = owed_results.pop_front();
        if (out_result.out_value !== want.out_value)
          flag_error($sformatf("result %0d out_value %h, want %h",
                               results_seen, out_result.out_value, want.out_value));
        if (out_result.out_left !== want.out_left)
          flag_error($sformatf("result %0d out_left %h, want %h",
                               results_seen, out_result.out_left, want.out_left));
        if (out_result.out_right !== want.out_right)
          flag_error($sformatf("result %0d out_right %h, want %h",
                               results_seen, out_result.out_right, want.out_right));
        if (out_result.found !== want.found)
          flag_error($sformatf("result %0d found %b, want %b",
                               results_seen, out_result.found, want.found));
        if (out_result.fill_count !== want.fill_count)
          flag_error($sformatf("result %0d fill_count %0d, want %0d",
                               results_seen, out_result.fill_count, want.fill_count));
        if (out_result.status !== want.status)
          flag_error($sformatf("result %0d status %0d, want %0d",
                               results_seen, out_result.status, want.status));
      end
      results_seen++;
    end
  end

  // Watchdog: any transfer on either side rearms it
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results owed",
               WATCHDOG_LIMIT, owed_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    seg_kind_t kind;
    int        seg_len;
    int        sent_random;
    bit        first_seg;

    held        = 0;
    sent_random = 0;
    first_seg   = 1'b1;

    // Directed part: empty array, extremes, range errors, every mode.
    //                     mode         pa  pb  value          left      right    fix st        fill
    directed_rows.push_back(row(MODE_POP,     0,  0, 32'h0,         16'h0,    16'h0,    1, ST_EMPTY, 0));
    directed_rows.push_back(row(MODE_READ,    0,  0, 32'h0,         16'h0,    16'h0,    1, ST_EMPTY, 0));
    directed_rows.push_back(row(MODE_TOP,     0,  0, 32'h0,         16'h0,    16'h0,    1, ST_EMPTY, 0));
    directed_rows.push_back(row(MODE_SEARCH,  0,  0, 32'hFFFF_FFFF, 16'h0,    16'h0,    1, ST_EMPTY, 0));
    directed_rows.push_back(row(MODE_WRITE,  63,  0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, ST_EMPTY, 0));
    directed_rows.push_back(row(MODE_SWAP,   63, 63, 32'h0,         16'h0,    16'h0,    1, ST_EMPTY, 0));
    directed_rows.push_back(row(MODE_REMOVE, 63,  0, 32'h0,         16'h0,    16'h0,    1, ST_EMPTY, 0));
    directed_rows.push_back(row(MODE_PUSH,   63, 63, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, ST_OK,    1));
    directed_rows.push_back(row(MODE_PUSH,    0,  0, 32'h0,         16'h0,    16'h0,    1, ST_OK,    2));
    directed_rows.push_back(row(MODE_PUSH,    0,  0, 32'h8000_0001, 16'h8001, 16'h7FFE, 1, ST_OK,    3));
    directed_rows.push_back(row(MODE_READ,    0,  0, 32'h0,         16'h0,    16'h0,    0, ST_OK,    0));
    directed_rows.push_back(row(MODE_READ,    2,  0, 32'h0,         16'h0,    16'h0,    0, ST_OK,    0));
    directed_rows.push_back(row(MODE_READ,    3,  0, 32'h0,         16'h0,    16'h0,    1, ST_RANGE, 3));
    directed_rows.push_back(row(MODE_READ,   63,  0, 32'h0,         16'h0,    16'h0,    1, ST_RANGE, 3));
    directed_rows.push_back(row(MODE_WRITE,   1,  0, 32'h5A5A_A5A5, 16'hA5A5, 16'h5A5A, 0, ST_OK,    0));
    directed_rows.push_back(row(MODE_WRITE,   3,  0, 32'h1,         16'h1,    16'h1,    1, ST_RANGE, 3));
    directed_rows.push_back(row(MODE_SWAP,    0,  2, 32'h0,         16'h0,    16'h0,    0, ST_OK,    0));
    directed_rows.push_back(row(MODE_SWAP,    0, 63, 32'h0,         16'h0,    16'h0,    1, ST_RANGE, 3));
    directed_rows.push_back(row(MODE_SEARCH,  0,  0, 32'hFFFF_FFFF, 16'h0,    16'h0,    0, ST_OK,    0));
    directed_rows.push_back(row(MODE_SEARCH,  0,  0, 32'h1234_5678, 16'h0,    16'h0,    0, ST_OK,    0));
    directed_rows.push_back(row(MODE_TOP,     0,  0, 32'h0,         16'h0,    16'h0,    0, ST_OK,    0));
    directed_rows.push_back(row(MODE_REMOVE,  0,  0, 32'h0,         16'h0,    16'h0,    0, ST_OK,    0));
    directed_rows.push_back(row(MODE_REMOVE,  2,  0, 32'h0,         16'h0,    16'h0,    1, ST_RANGE, 2));
    directed_rows.push_back(row(MODE_POP,     0,  0, 32'h0,         16'h0,    16'h0,    0, ST_OK,    0));
    directed_rows.push_back(row(MODE_POP,     0,  0, 32'h0,         16'h0,    16'h0,    0, ST_OK,    0));
    directed_rows.push_back(row(MODE_POP,     0,  0, 32'h0,         16'h0,    16'h0,    1, ST_EMPTY, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // light idling over the directed rows so gaps land on short ops too
    idle_pct = 20;
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].fixed_res, directed_rows[i].want);

    // Random part in segments. The first one fills the array so full pushes
    // and the longest removes/searches show up early; drain segments empty it.
    while (sent_random < RANDOM_ITEMS) begin
      kind      = first_seg ? SEG_FILL : seg_kind_t'($urandom_range(0, 2));
      seg_len   = first_seg ? 160 : $urandom_range(80, 200);
      first_seg = 1'b0;
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      for (int n = 0; n < seg_len && sent_random < RANDOM_ITEMS; n++) begin
        quiet = (sent_random >= RANDOM_ITEMS - QUIET_ITEMS);
        send_request(random_request(kind), 1'b0, '0);
        sent_random++;
      end
    end

    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    // stray late results would be caught by the checker here
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (%0d random), %0d results checked, peak fill %0d.",
             items_sent, sent_random, results_seen, max_held);
    $display("Pushes on full %0d, empty-array fails %0d, range fails %0d, search hits %0d.",
             full_pushes, empty_fails, range_fails, search_hits);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
